@@ src/glyph_moment_orientation_macros.svh @@
// Assertion macros for the glyph moment orientation checker.
`ifndef GLYPH_MOMENT_ORIENTATION_MACROS_SVH
`define GLYPH_MOMENT_ORIENTATION_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define GMO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define GMO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/gmo_pkg.sv @@
// Shared constants, types and the arctangent table of the glyph moment orientation block.
`timescale 1ns / 1ps

package gmo_pkg;

    // Frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;
    localparam int COL_IDX_W  = $clog2(MAX_WIDTH);
    localparam int ROW_IDX_W  = $clog2(MAX_HEIGHT);
    localparam int WGT_W      = DIM_W + 1;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd1024;

    // Result widths
    localparam int SUM_W           = 29;
    localparam int ANGLE_W         = 15;
    localparam int ANGLE_FRAC_BITS = 13;

    // CORDIC datapath
    localparam int WORK_BITS    = 40;
    localparam int CORDIC_STEPS = 41;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int NORM_MSB     = 58;
    localparam int PRE_SHIFT    = NORM_MSB - (SUM_W - 1);
    localparam int XY_W         = NORM_MSB + 4;
    localparam int Z_W          = WORK_BITS + 4;
    localparam int ROUND_SH     = WORK_BITS - ANGLE_FRAC_BITS;

    // Frame queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_LSB = 2;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // Moments of one finished frame, passed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] row_sum;
        logic [SUM_W-1:0] col_sum;
    } t_frame_rec;

    // Queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // atan(2^-i) in Q40; entry 0 is pi/4 built from atan(1/2) + atan(1/3)
    function automatic logic signed [Z_W-1:0] atan_q40(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            6'd0:  v = 44'sd863554413089;
            6'd1:  v = 44'sd509785937287;
            6'd2:  v = 44'sd269356888665;
            6'd3:  v = 44'sd136729762476;
            6'd4:  v = 44'sd68630207382;
            6'd5:  v = 44'sd34348560106;
            6'd6:  v = 44'sd17178471285;
            6'd7:  v = 44'sd8589759836;
            6'd8:  v = 44'sd4294945451;
            6'd9:  v = 44'sd2147480917;
            6'd10: v = 44'sd1073741483;
            6'd11: v = 44'sd536870869;
            6'd12: v = 44'sd268435451;
            6'd13: v = 44'sd134217727;
            // small angles: the cubic term rounds away, leaving 2^(40-i)
            default: begin
                if (i <= STEP_W'(WORK_BITS)) begin
                    v = Z_W'(1) << (STEP_W'(WORK_BITS) - i);
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

@@ src/glyph_moment_orientation.sv @@
// Top level of the glyph moment orientation block: configuration registers and channel wiring.
//
// Pixels enter one per beat in raster order on the input queue side (push/full, i_ink).
// The front end accepts a pixel every cycle while full is low and keeps row and
// column moments about the image center lines; full is high only while the two-entry
// frame queue is full. After the last pixel of a frame its moments go to the queue,
// and the back end turns them into an angle: a load, up to 9 normalization shifts
// and a check, 41 CORDIC iterations, then rounding (when both moments are zero it
// goes from the load straight to the result). One result beat per frame leaves on the
// output
// queue side (empty/pop, row moment, column moment, orientation in Q2.13 radians).
// A waiting result is held while pop is low; the back end then parks on the next
// finished angle, the queue fills, and full holds off further pixels.
// Synchronous reset empties both queues, clears the moments and sets width and
// height to 1024. A write to either register restarts the frame in progress.
// Registers: image width at byte address 0, image height at 4 (APB, no wait states).
`timescale 1ns / 1ps

module glyph_moment_orientation (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // pixel channel
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 i_ink,
    // result channel
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [gmo_pkg::SUM_W-1:0]     o_row_moment,
    output logic signed [gmo_pkg::SUM_W-1:0]     o_column_moment,
    output logic signed [gmo_pkg::ANGLE_W-1:0]   o_orientation,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [gmo_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [gmo_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [gmo_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import gmo_pkg::*;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             cfg_wr;
    t_reg_idx         reg_idx;
    logic             pix_accept;
    logic             rec_push;
    logic             rec_pop;
    t_frame_rec       rec_in;
    t_frame_rec       rec_out;
    t_queue_status    q_status;

    // Register access
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[REG_IDX_LSB]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Pixel beat handshake
    assign full       = q_status.full;
    assign pix_accept = push && !full;

    gmo_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (cfg_wr),
        .i_width_raw  (r_width),
        .i_height_raw (r_height),
        .i_accept     (pix_accept),
        .i_ink        (i_ink),
        .o_rec_push   (rec_push),
        .o_rec        (rec_in)
    );

    gmo_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (rec_push),
        .i_data   (rec_in),
        .i_pop    (rec_pop),
        .o_data   (rec_out),
        .o_status (q_status)
    );

    gmo_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (q_status),
        .i_rec           (rec_out),
        .o_rec_pop       (rec_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_row_moment    (o_row_moment),
        .o_column_moment (o_column_moment),
        .o_orientation   (o_orientation)
    );

endmodule

@@ src/gmo_front.sv @@
// Pixel front end: raster position tracking and row/column moment accumulation.
`timescale 1ns / 1ps

module gmo_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic [gmo_pkg::DIM_W-1:0]  i_width_raw,
    input  logic [gmo_pkg::DIM_W-1:0]  i_height_raw,
    input  logic                       i_accept,
    input  logic                       i_ink,
    output logic                       o_rec_push,
    output gmo_pkg::t_frame_rec        o_rec
);
    import gmo_pkg::*;

    // Clamp a programmed dimension into 1..max
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw, input int max_dim);
        logic [DIM_W-1:0] d;
        if (raw == '0) begin
            d = DIM_W'(1);
        end else if (int'(raw) > max_dim) begin
            d = DIM_W'(max_dim);
        end else begin
            d = raw;
        end
        return d;
    endfunction

    // Distance from the center line: positive before it, zero on an odd middle, negative after
    function automatic logic signed [WGT_W-1:0] weight_of(input logic [DIM_W-1:0] k,
                                                          input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] hi;
        logic signed [WGT_W-1:0] w;
        h  = n >> 1;
        hi = n - h;
        if (k < h) begin
            w = $signed({1'b0, h - k});
        end else if (k < hi) begin
            w = '0;
        end else begin
            w = -$signed({1'b0, k - hi + DIM_W'(1)});
        end
        return w;
    endfunction

    logic [COL_IDX_W-1:0]    r_col_idx, n_col_idx;
    logic [ROW_IDX_W-1:0]    r_row_idx, n_row_idx;
    logic signed [SUM_W-1:0] r_row_sum, n_row_sum;
    logic signed [SUM_W-1:0] r_col_sum, n_col_sum;

    logic [DIM_W-1:0]        width_eff;
    logic [DIM_W-1:0]        height_eff;
    logic [DIM_W-1:0]        col_next;
    logic [DIM_W-1:0]        row_next;
    logic signed [WGT_W-1:0] col_wgt;
    logic signed [WGT_W-1:0] row_wgt;
    logic                    col_last;
    logic                    row_last;

    assign width_eff  = eff_dim(i_width_raw, MAX_WIDTH);
    assign height_eff = eff_dim(i_height_raw, MAX_HEIGHT);

    // Weights of the current pixel and the running sums including it
    always_comb begin
        col_wgt   = weight_of(DIM_W'(r_col_idx), width_eff);
        row_wgt   = weight_of(DIM_W'(r_row_idx), height_eff);
        n_row_sum = r_row_sum + (i_ink ? SUM_W'(row_wgt) : '0);
        n_col_sum = r_col_sum + (i_ink ? SUM_W'(col_wgt) : '0);
    end

    // Raster position advance
    always_comb begin
        col_next  = DIM_W'(r_col_idx) + DIM_W'(1);
        row_next  = DIM_W'(r_row_idx) + DIM_W'(1);
        col_last  = col_next >= width_eff;
        row_last  = row_next >= height_eff;
        n_col_idx = col_last ? '0 : COL_IDX_W'(col_next);
        n_row_idx = col_last ? (row_last ? '0 : ROW_IDX_W'(row_next)) : r_row_idx;
    end

    assign o_rec_push      = i_accept && col_last && row_last;
    assign o_rec.row_sum   = n_row_sum;
    assign o_rec.col_sum   = n_col_sum;

    // Position and sums; the frame end and any register write start over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col_idx <= '0;
            r_row_idx <= '0;
            r_row_sum <= '0;
            r_col_sum <= '0;
        end else if (i_accept) begin
            r_col_idx <= n_col_idx;
            r_row_idx <= n_row_idx;
            if (col_last && row_last) begin
                r_row_sum <= '0;
                r_col_sum <= '0;
            end else begin
                r_row_sum <= n_row_sum;
                r_col_sum <= n_col_sum;
            end
        end
    end

endmodule

@@ src/gmo_queue.sv @@
// Short queue of finished frame moments between the front and back ends.
`timescale 1ns / 1ps

module gmo_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  gmo_pkg::t_frame_rec     i_data,
    input  logic                    i_pop,
    output gmo_pkg::t_frame_rec     o_data,
    output gmo_pkg::t_queue_status  o_status
);
    import gmo_pkg::*;

    t_frame_rec        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] q;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + QPTR_W'(1);
        end
        return q;
    endfunction

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

@@ src/gmo_back.sv @@
// Back end: normalizes the moments, runs the vectoring CORDIC and holds the result beat.
`timescale 1ns / 1ps

module gmo_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gmo_pkg::t_queue_status               i_q_status,
    input  gmo_pkg::t_frame_rec                  i_rec,
    output logic                                 o_rec_pop,
    input  logic                                 i_pop,
    output logic                                 o_empty,
    output logic signed [gmo_pkg::SUM_W-1:0]     o_row_moment,
    output logic signed [gmo_pkg::SUM_W-1:0]     o_column_moment,
    output logic signed [gmo_pkg::ANGLE_W-1:0]   o_orientation
);
    import gmo_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NORM,
        S_ITER,
        S_DONE
    } t_state;

    localparam logic [Z_W-1:0] ROUND_HALF = Z_W'(1) << (ROUND_SH - 1);

    t_state                  r_state;
    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic signed [Z_W-1:0]   r_z;
    logic [STEP_W-1:0]       r_step;
    logic                    r_row_neg;
    logic [SUM_W-1:0]        r_row;
    logic [SUM_W-1:0]        r_col;
    logic                    r_res_valid;

    logic signed [XY_W-1:0]  ext_row;
    logic signed [XY_W-1:0]  ext_col;
    logic signed [XY_W-1:0]  abs_row;
    logic signed [XY_W-1:0]  abs_col;
    logic [XY_W-1:0]         mag_or;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [Z_W-1:0]   step_angle;
    logic [Z_W-1:0]          mag_z;
    logic [Z_W-1:0]          rnd_z;
    logic [ANGLE_W-1:0]      angle_mag;
    logic signed [ANGLE_W-1:0] angle;
    logic                    res_slot;
    logic                    res_load;

    // Magnitudes of the incoming moments
    always_comb begin
        ext_row = XY_W'($signed(i_rec.row_sum));
        ext_col = XY_W'($signed(i_rec.col_sum));
        abs_row = ext_row[XY_W-1] ? -ext_row : ext_row;
        abs_col = ext_col[XY_W-1] ? -ext_col : ext_col;
    end

    // One CORDIC micro-rotation and the final rounding
    always_comb begin
        mag_or     = r_x | r_y;
        dx         = r_y >>> r_step;
        dy         = r_x >>> r_step;
        step_angle = atan_q40(r_step);
        mag_z      = r_z[Z_W-1] ? -r_z : r_z;
        rnd_z      = (mag_z + ROUND_HALF) >> ROUND_SH;
        angle_mag  = ANGLE_W'(rnd_z);
        angle      = r_z[Z_W-1] ? -$signed(angle_mag) : $signed(angle_mag);
    end

    assign o_rec_pop = (r_state == S_IDLE) && !i_q_status.empty;
    assign res_slot  = !r_res_valid || i_pop;
    assign res_load  = (r_state == S_DONE) && res_slot;
    assign o_empty   = !r_res_valid;

    // Sequencer, datapath and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            // a new result replaces the one popped in the same cycle
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_row     <= i_rec.row_sum;
                        r_col     <= i_rec.col_sum;
                        r_row_neg <= i_rec.row_sum[SUM_W-1];
                        r_x       <= abs_col <<< PRE_SHIFT;
                        r_y       <= abs_row <<< PRE_SHIFT;
                        r_z       <= '0;
                        r_step    <= '0;
                        if (i_rec.row_sum == '0 && i_rec.col_sum == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    // shift left until the larger magnitude reaches the top bit
                    if (mag_or[NORM_MSB]) begin
                        if (r_row_neg) begin
                            r_y <= -r_y;
                        end
                        r_state <= S_ITER;
                    end else if (mag_or[NORM_MSB -: 4] == '0) begin
                        r_x <= r_x <<< 4;
                        r_y <= r_y <<< 4;
                    end else begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end
                end
                S_ITER: begin
                    // rotate toward y = 0
                    if (!r_y[XY_W-1]) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + step_angle;
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - step_angle;
                    end
                    if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_DONE: begin
                    if (res_load) begin
                        o_row_moment    <= $signed(r_row);
                        o_column_moment <= $signed(r_col);
                        o_orientation   <= angle;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/gmo_checker.sv @@
// Port-level checker for the glyph moment orientation block, bound to the top level.
`timescale 1ns / 1ps
`include "glyph_moment_orientation_macros.svh"

module gmo_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 full,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic signed [gmo_pkg::SUM_W-1:0]     o_row_moment,
    input  logic signed [gmo_pkg::SUM_W-1:0]     o_column_moment,
    input  logic signed [gmo_pkg::ANGLE_W-1:0]   o_orientation
);
    import gmo_pkg::*;

    // Reset leaves no result pending and the pixel side open
    `GMO_ASSERT_IMP(a_reset_clean, $past(!i_rst_n), empty && !full, "result or full after reset")

    // A stalled result beat holds still
    `GMO_ASSERT_NXT(a_result_hold, !empty && !pop, !empty && $stable(o_row_moment) && $stable(o_column_moment) && $stable(o_orientation), "result changed while stalled")

    // Both moments zero gives a zero angle
    `GMO_ASSERT_IMP(a_zero_angle, !empty && o_row_moment == '0 && o_column_moment == '0, o_orientation == '0, "nonzero angle for zero moments")

    // Angle sign follows the row moment
    `GMO_ASSERT_IMP(a_sign_neg, !empty && o_row_moment[SUM_W-1], o_orientation[ANGLE_W-1] || o_orientation == '0, "positive angle for negative row moment")
    `GMO_ASSERT_IMP(a_sign_pos, !empty && !o_row_moment[SUM_W-1], !o_orientation[ANGLE_W-1], "negative angle for nonnegative row moment")

endmodule

bind glyph_moment_orientation gmo_checker u_gmo_checker (.*);
